// ----- rtl/core/hrf_pkg.sv -----
// hrf_pkg: shared constants, word types and register codes of the hit region finder
// no dependencies; used by the channel interfaces and the top level

package hrf_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int THR_BITS    = 16;
    localparam int IDX_W       = 12;
    localparam int CNT_W       = $clog2(MAX_SAMPLES);

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    typedef enum logic [0:0] {
        CFG_THR_IND = 1'b0,
        CFG_THR_COL = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        EV_PEAK = 1'b0,
        EV_END  = 1'b1
    } t_event_kind;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          collection_plane;
        logic                          last_sample;
    } t_in_word;

    typedef struct packed {
        t_event_kind                   event_kind;
        logic [IDX_W-1:0]              region_begin;
        logic [IDX_W-1:0]              event_index;
        logic signed [SAMPLE_BITS-1:0] peak_amplitude;
        logic                          last_of_run;
    } t_out_word;

endpackage

// ----- rtl/core/hrf_in_if.sv -----
// hrf_in_if: sample channel, valid/ready handshake carrying one sample word
// depends on hrf_pkg for the word type

interface hrf_in_if;
    logic              valid;
    logic              ready;
    hrf_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/hrf_out_if.sv -----
// hrf_out_if: event channel, valid/ready handshake carrying one event word
// depends on hrf_pkg for the word type

interface hrf_out_if;
    logic               valid;
    logic               ready;
    hrf_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/waveform_hit_region_finder.sv -----
// waveform_hit_region_finder: three-sample extrema test with threshold, per-wire state
// depends on hrf_pkg, hrf_in_if and hrf_out_if
// event words are registered into the output queue when their sample word is accepted
// throughput: one sample word per cycle while the output queue holds at most two words;
// a sample that causes two events writes both words into the four-word output queue
// reset (synchronous, active low): thresholds zero, wire state cleared, queue empty

module waveform_hit_region_finder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hrf_in_if.sink                         i_in,
    hrf_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  hrf_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [hrf_pkg::THR_BITS-1:0]   i_cfg_data
);

    localparam int SB  = hrf_pkg::SAMPLE_BITS;
    localparam int CW  = hrf_pkg::CNT_W;
    localparam int AW  = hrf_pkg::FIFO_AW;

    logic signed [hrf_pkg::THR_BITS-1:0] r_thr_ind, r_thr_col;
    logic signed [SB-1:0] r_prev, r_prev2, n_prev, n_prev2;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_peak_open, n_peak_open;
    logic [CW-1:0]        r_region, n_region;

    hrf_pkg::t_out_word   r_fifo [hrf_pkg::FIFO_DEPTH];
    logic [AW-1:0]        r_wr_ptr, r_rd_ptr;
    logic [AW:0]          r_count, n_count;

    logic                 in_acc, out_acc;
    logic signed [SB-1:0] s;
    logic signed [hrf_pkg::THR_BITS-1:0] thr;
    logic [CW-1:0]        centre;
    logic                 win, is_min, is_max, peak_after, have_win, have_last;
    hrf_pkg::t_out_word   win_word, last_word, word0, word1;
    logic [1:0]           n_push;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    assign i_in.ready  = (r_count <= (AW+1)'(hrf_pkg::FIFO_DEPTH - 2));
    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_fifo[r_rd_ptr];

    // window test on the centre sample
    always_comb begin
        s      = i_in.data.sample;
        thr    = i_in.data.collection_plane ? r_thr_col : r_thr_ind;
        centre = r_cnt - CW'(1);
        win    = (r_cnt >= CW'(2));
        is_min = win && (r_prev2 > r_prev) && (r_prev < s);
        is_max = win && !is_min && (r_prev2 < r_prev) && (r_prev > s) && (r_prev > thr);

        if (is_min) begin
            peak_after = 1'b0;
        end else if (is_max) begin
            peak_after = 1'b1;
        end else begin
            peak_after = r_peak_open;
        end

        have_win  = (is_min && r_peak_open) || is_max;
        have_last = i_in.data.last_sample && peak_after;

        win_word.event_kind     = is_max ? hrf_pkg::EV_PEAK : hrf_pkg::EV_END;
        win_word.region_begin   = is_max ? hrf_pkg::IDX_W'(r_region) : '0;
        win_word.event_index    = hrf_pkg::IDX_W'(centre);
        win_word.peak_amplitude = is_max ? r_prev : '0;
        win_word.last_of_run    = !have_last;

        last_word.event_kind     = hrf_pkg::EV_END;
        last_word.region_begin   = '0;
        last_word.event_index    = hrf_pkg::IDX_W'(r_cnt);
        last_word.peak_amplitude = '0;
        last_word.last_of_run    = 1'b1;

        word0  = have_win ? win_word : last_word;
        word1  = last_word;
        n_push = in_acc ? ({1'b0, have_win} + {1'b0, have_last}) : 2'd0;
    end

    // wire state update
    always_comb begin
        n_prev      = r_prev;
        n_prev2     = r_prev2;
        n_cnt       = r_cnt;
        n_peak_open = r_peak_open;
        n_region    = r_region;
        if (in_acc) begin
            if (i_in.data.last_sample) begin
                n_prev      = '0;
                n_prev2     = '0;
                n_cnt       = '0;
                n_peak_open = 1'b0;
                n_region    = '0;
            end else begin
                n_prev2     = r_prev;
                n_prev      = s;
                n_peak_open = peak_after;
                if (r_cnt != CW'(hrf_pkg::MAX_SAMPLES - 1)) begin
                    n_cnt = r_cnt + CW'(1);
                end
                if (is_min) begin
                    n_region = r_peak_open ? r_cnt : centre;
                end
            end
        end
        n_count = r_count + (AW+1)'(n_push) - (AW+1)'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_ind   <= '0;
            r_thr_col   <= '0;
            r_prev      <= '0;
            r_prev2     <= '0;
            r_cnt       <= '0;
            r_peak_open <= 1'b0;
            r_region    <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hrf_pkg::CFG_THR_IND: r_thr_ind <= i_cfg_data;
                    hrf_pkg::CFG_THR_COL: r_thr_col <= i_cfg_data;
                    default: ;
                endcase
            end
            r_prev      <= n_prev;
            r_prev2     <= n_prev2;
            r_cnt       <= n_cnt;
            r_peak_open <= n_peak_open;
            r_region    <= n_region;
            r_wr_ptr    <= r_wr_ptr + AW'(n_push);
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count     <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= word0;
        end
        if (n_push == 2'd2) begin
            r_fifo[r_wr_ptr + AW'(1)] <= word1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(hrf_pkg::FIFO_DEPTH))
        else $error("event queue overfilled");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.data.last_sample) |=> (r_cnt == '0) && !r_peak_open)
        else $error("wire state not cleared after last sample");

    a_peak_has_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak_open |-> (r_cnt >= CW'(2)))
        else $error("peak open without a full window");

    a_two_words_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_push == 2'd2) |-> (word1.event_kind == hrf_pkg::EV_END) && !word0.last_of_run)
        else $error("two-word run not closed by an end word");

endmodule
